@@ rtl/msa_pkg.sv @@
// Shared types and constants for the multi-stack shared-array block.
// Used by the top level. Depends on nothing.
package msa_pkg;

    localparam int DEPTH_DEF      = 1024;
    localparam int MAX_STACKS_DEF = 16;
    localparam int CNT_W          = 5;
    localparam int CNT_TAB        = 1 << CNT_W;
    localparam int DATA_W         = 32;
    localparam int STAT_W         = 2;

    typedef enum logic [STAT_W-1:0] {
        ST_OK       = 2'd0,
        ST_INVALID  = 2'd1,
        ST_OVERFLOW = 2'd2,
        ST_EMPTY    = 2'd3
    } t_status;

    typedef enum logic {
        OP_PUSH = 1'b0,
        OP_POP  = 1'b1
    } t_op;

    typedef enum logic [1:0] {
        S_IDLE,
        S_CALC,
        S_POP
    } t_state;

endpackage

@@ rtl/msa_ram.sv @@
// Generic single-port-write, single-port-read RAM with registered read data.
// Used for the fill counts and the item store. Depends on nothing.
module msa_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16,
    localparam int AW   = $clog2(DEPTH)
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

@@ rtl/multi_stack_shared_array.sv @@
// Top level of the multi-stack shared-array block: control, region math, two RAMs.
// Depends on msa_pkg and msa_ram.
//
// Usage:
//   Command channel: drive i_opcode, i_stack_number and i_push_value with start
//   high; the beat is taken at the edge where start is high and busy is low.
//   Result channel: o_status and o_pop_value hold for one cycle with o_strobe
//   high; the receiver cannot stall it, so it must sample every strobe.
//   Config channel: i_cfg_data is taken when i_cfg_valid and o_cfg_ready are
//   both high; o_cfg_ready is low while a command is in flight or start is
//   high. A write sets the stack count (0 reads as 1, saturates at MAX_STACKS)
//   and empties all stacks at once through the per-stack valid bits.
//   Sequence: the result strobe follows the calculation state for a push, a
//   failed pop or a bad stack number, and the extra pop state for a good
//   pop, which waits on the item RAM read port. busy drops with the strobe,
//   so a new command is taken only once the last one has its result.
//   The registered fill count RAM read and item RAM read set this order.
//   Reset: synchronous, active low; one stack, all stacks empty, no cleanup
//   pass. Item words are never cleared.
module multi_stack_shared_array
    import msa_pkg::*;
#(
    parameter int DEPTH      = DEPTH_DEF,
    parameter int MAX_STACKS = MAX_STACKS_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              start,
    output logic              busy,
    input  logic              i_opcode,
    input  logic [CNT_W-1:0]  i_stack_number,
    input  logic [DATA_W-1:0] i_push_value,
    output logic              o_strobe,
    output logic [STAT_W-1:0] o_status,
    output logic [DATA_W-1:0] o_pop_value,
    input  logic              i_cfg_valid,
    output logic              o_cfg_ready,
    input  logic [CNT_W-1:0]  i_cfg_data
);

    localparam int KW = $clog2(MAX_STACKS);
    localparam int AW = $clog2(DEPTH);
    localparam int FW = $clog2(DEPTH + 1);

    t_state            r_state, n_state;
    logic [CNT_W-1:0]  r_count;
    logic [FW-1:0]     r_size;
    logic [MAX_STACKS-1:0] r_fill_vld;

    t_op               r_op;
    logic [KW-1:0]     r_k;
    logic [FW-1:0]     r_base;
    logic              r_invalid;
    logic              r_last;
    logic [DATA_W-1:0] r_val;

    logic              r_strobe, n_strobe;
    t_status           r_status, n_status;
    logic [DATA_W-1:0] r_pop_value, n_pop_value;

    logic [FW-1:0]     w_size_tab [CNT_TAB];
    logic              w_accept;
    logic              w_cfg_wr;
    logic [CNT_W-1:0]  w_cfg_cnt;
    logic [KW-1:0]     w_k;
    logic [FW+KW-1:0]  w_prod;
    logic [FW-1:0]     w_fill_rd;
    logic [FW-1:0]     w_fill;
    logic [FW-1:0]     w_cap;
    logic              w_full;
    logic              w_empty;
    logic              w_push_ok;
    logic              w_pop_ok;
    logic              w_fill_we;
    logic [FW-1:0]     w_fill_next;
    logic              w_item_we;
    logic [AW-1:0]     w_item_waddr;
    logic [AW-1:0]     w_item_raddr;
    logic [DATA_W-1:0] w_item_rd;

    for (genvar g = 0; g < CNT_TAB; g++) begin : g_size
        localparam int unsigned QUOT = DEPTH / (g + 1);
        assign w_size_tab[g] = FW'(QUOT);
    end

    assign busy        = (r_state != S_IDLE);
    assign o_cfg_ready = ~busy & ~start;
    assign w_accept    = start & ~busy;
    assign w_cfg_wr    = i_cfg_valid & o_cfg_ready;

    always_comb begin
        w_cfg_cnt = i_cfg_data;
        if (w_cfg_cnt == '0) begin
            w_cfg_cnt = CNT_W'(1);
        end
        if (32'(w_cfg_cnt) > MAX_STACKS) begin
            w_cfg_cnt = CNT_W'(MAX_STACKS);
        end
    end

    assign w_k    = KW'(i_stack_number - CNT_W'(1));
    assign w_prod = r_size * w_k;

    assign w_fill   = r_fill_vld[r_k] ? w_fill_rd : '0;
    assign w_cap    = r_last ? (FW'(DEPTH) - r_base) : r_size;
    assign w_full   = (w_fill >= w_cap);
    assign w_empty  = (w_fill == '0);
    assign w_push_ok = (r_state == S_CALC) && !r_invalid && (r_op == OP_PUSH) && !w_full;
    assign w_pop_ok  = (r_state == S_CALC) && !r_invalid && (r_op == OP_POP) && !w_empty;

    assign w_fill_we    = w_push_ok | w_pop_ok;
    assign w_fill_next  = w_push_ok ? (w_fill + FW'(1)) : (w_fill - FW'(1));
    assign w_item_we    = w_push_ok;
    assign w_item_waddr = AW'(r_base + w_fill);
    assign w_item_raddr = AW'(r_base + w_fill - FW'(1));

    msa_ram #(
        .WIDTH (FW),
        .DEPTH (MAX_STACKS)
    ) u_fill_ram (
        .i_clk   (i_clk),
        .i_we    (w_fill_we),
        .i_waddr (r_k),
        .i_wdata (w_fill_next),
        .i_raddr (w_k),
        .o_rdata (w_fill_rd)
    );

    msa_ram #(
        .WIDTH (DATA_W),
        .DEPTH (DEPTH)
    ) u_item_ram (
        .i_clk   (i_clk),
        .i_we    (w_item_we),
        .i_waddr (w_item_waddr),
        .i_wdata (r_val),
        .i_raddr (w_item_raddr),
        .o_rdata (w_item_rd)
    );

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    n_state = S_CALC;
                end
            end
            S_CALC: begin
                n_state = w_pop_ok ? S_POP : S_IDLE;
            end
            S_POP: begin
                n_state = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_comb begin
        n_strobe    = 1'b0;
        n_status    = ST_OK;
        n_pop_value = '0;
        unique case (r_state)
            S_IDLE: begin
                n_strobe = 1'b0;
            end
            S_CALC: begin
                if (!w_pop_ok) begin
                    n_strobe = 1'b1;
                    if (r_invalid) begin
                        n_status = ST_INVALID;
                    end else if (r_op == OP_PUSH) begin
                        n_status = w_full ? ST_OVERFLOW : ST_OK;
                    end else begin
                        n_status = ST_EMPTY;
                    end
                end
            end
            S_POP: begin
                n_strobe    = 1'b1;
                n_status    = ST_OK;
                n_pop_value = w_item_rd;
            end
            default: begin
                n_strobe = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_strobe   <= 1'b0;
            r_count    <= CNT_W'(1);
            r_size     <= FW'(DEPTH);
            r_fill_vld <= '0;
        end else begin
            r_state  <= n_state;
            r_strobe <= n_strobe;
            if (w_cfg_wr) begin
                r_count    <= w_cfg_cnt;
                r_size     <= w_size_tab[CNT_W'(w_cfg_cnt - CNT_W'(1))];
                r_fill_vld <= '0;
            end else if (w_fill_we) begin
                r_fill_vld[r_k] <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_status    <= n_status;
        r_pop_value <= n_pop_value;
        if (w_accept) begin
            r_op      <= t_op'(i_opcode);
            r_k       <= w_k;
            r_base    <= FW'(w_prod);
            r_val     <= i_push_value;
            r_invalid <= (i_stack_number == '0) || (i_stack_number > r_count)
                         || (32'(i_stack_number) > MAX_STACKS);
            r_last    <= (i_stack_number == r_count);
        end
    end

    assign o_strobe    = r_strobe;
    assign o_status    = r_status;
    assign o_pop_value = r_pop_value;

`ifndef ASSERT_OFF
    a_strobe_gap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |=> !o_strobe)
        else $error("result strobe in two consecutive cycles");

    a_accept_calc: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept |=> (r_state == S_CALC))
        else $error("accepted command did not enter calculation");

    a_fail_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && (r_status != ST_OK)) |-> (o_pop_value == '0))
        else $error("failed command returned nonzero pop value");

    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_count != '0) && (32'(r_count) <= MAX_STACKS))
        else $error("stack count out of range");

    a_cfg_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cfg_wr |=> (r_fill_vld == '0))
        else $error("count write did not empty all stacks");
`endif

endmodule

@@ verif/testbench.sv @@
// Testbench for multi_stack_shared_array: directed and random push/pop commands
// over many stack-count settings, checked against a shadow model of every stack.
// Depends on msa_pkg and the RTL of the block.
module testbench;
    import msa_pkg::*;

    localparam int CYCLE_LIMIT = 400000;
    localparam int TOTAL_ITEMS = 950;

    typedef struct packed {
        t_status           status;
        logic [DATA_W-1:0] pop_value;
    } t_stack_outcome;

    class t_stack_tracker;
        int unsigned       active_count;
        int unsigned       fill_level[MAX_STACKS_DEF];
        logic [DATA_W-1:0] item_mem[DEPTH_DEF];
        t_stack_outcome    expected_outcomes[$];
        int unsigned       status_tally[4];
        int unsigned       mismatches;

        function new();
            active_count = 1;
            mismatches = 0;
            foreach (fill_level[i]) fill_level[i] = 0;
            foreach (status_tally[i]) status_tally[i] = 0;
        endfunction

        function void apply_count(logic [CNT_W-1:0] value);
            int unsigned c;
            c = value;
            if (c == 0) c = 1;
            if (c > MAX_STACKS_DEF) c = MAX_STACKS_DEF;
            active_count = c;
            foreach (fill_level[i]) fill_level[i] = 0;
        endfunction

        function void note_command(t_op op, logic [CNT_W-1:0] num, logic [DATA_W-1:0] value);
            t_stack_outcome o;
            int unsigned    k;
            int unsigned    span;
            int unsigned    base;
            int unsigned    cap;
            o.status = ST_OK;
            o.pop_value = '0;
            if (num == 0 || num > active_count) begin
                o.status = ST_INVALID;
            end else begin
                k = num - 1;
                span = DEPTH_DEF / active_count;
                base = span * k;
                cap = (k + 1 >= active_count) ? DEPTH_DEF - base : span;
                if (op == OP_PUSH) begin
                    if (fill_level[k] >= cap) begin
                        o.status = ST_OVERFLOW;
                    end else begin
                        item_mem[base + fill_level[k]] = value;
                        fill_level[k]++;
                    end
                end else if (fill_level[k] == 0) begin
                    o.status = ST_EMPTY;
                end else begin
                    fill_level[k]--;
                    o.pop_value = item_mem[base + fill_level[k]];
                end
            end
            expected_outcomes.push_back(o);
        endfunction

        function void check_result(logic [STAT_W-1:0] st, logic [DATA_W-1:0] pv);
            t_stack_outcome o;
            if (expected_outcomes.size() == 0) begin
                $error("unexpected result: status %0d, pop_value %h", st, pv);
                mismatches++;
                return;
            end
            o = expected_outcomes.pop_front();
            status_tally[o.status]++;
            if (st !== o.status) begin
                $error("status: expected %0d, actual %0d", o.status, st);
                mismatches++;
            end
            if (pv !== o.pop_value) begin
                $error("pop_value: expected %h, actual %h", o.pop_value, pv);
                mismatches++;
            end
        endfunction
    endclass

    logic              i_clk = 1'b0;
    logic              i_rst_n = 1'b0;
    logic              start = 1'b0;
    logic              busy;
    logic              i_opcode = 1'b0;
    logic [CNT_W-1:0]  i_stack_number = '0;
    logic [DATA_W-1:0] i_push_value = '0;
    logic              o_strobe;
    logic [STAT_W-1:0] o_status;
    logic [DATA_W-1:0] o_pop_value;
    logic              i_cfg_valid = 1'b0;
    logic              o_cfg_ready;
    logic [CNT_W-1:0]  i_cfg_data = '0;

    t_stack_tracker tracker;
    int unsigned  cycle_count = 0;
    int unsigned  commands_sent = 0;
    int unsigned  count_writes = 0;
    int unsigned  burst_left = 0;

    multi_stack_shared_array dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .start          (start),
        .busy           (busy),
        .i_opcode       (i_opcode),
        .i_stack_number (i_stack_number),
        .i_push_value   (i_push_value),
        .o_strobe       (o_strobe),
        .o_status       (o_status),
        .o_pop_value    (o_pop_value),
        .i_cfg_valid    (i_cfg_valid),
        .o_cfg_ready    (o_cfg_ready),
        .i_cfg_data     (i_cfg_data)
    );

    always begin
        i_clk = 1'b0;
        #10;
        i_clk = 1'b1;
        #10;
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("tb: failure");
            $finish;
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_strobe) begin
            tracker.check_result(o_status, o_pop_value);
        end
    end

    task automatic idle_for(input int unsigned n);
        @(negedge i_clk);
        start <= 1'b0;
        repeat (n - 1) @(negedge i_clk);
    endtask

    task automatic send_command(input t_op op, input logic [CNT_W-1:0] num,
                                input logic [DATA_W-1:0] value);
        if (burst_left == 0) begin
            idle_for($urandom_range(1, 6));
            burst_left = $urandom_range(1, 40);
        end
        burst_left--;
        @(negedge i_clk);
        start <= 1'b1;
        i_opcode <= op;
        i_stack_number <= num;
        i_push_value <= value;
        do @(posedge i_clk); while (busy);
        tracker.note_command(op, num, value);
        commands_sent++;
    endtask

    task automatic write_count(input logic [CNT_W-1:0] value);
        @(negedge i_clk);
        start <= 1'b0;
        while (tracker.expected_outcomes.size() != 0) @(posedge i_clk);
        @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_data <= value;
        do @(posedge i_clk); while (!o_cfg_ready);
        tracker.apply_count(value);
        count_writes++;
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
        burst_left = 0;
    endtask

    initial begin
        int unsigned       phase_len;
        int unsigned       focus;
        int unsigned       push_pct;
        int unsigned       pick;
        logic [CNT_W-1:0]  num;
        t_op               op;

        tracker = new();
        repeat (11) @(negedge i_clk);
        i_rst_n <= 1'b1;

        write_count(5'd0);
        send_command(OP_PUSH, 5'd1, 32'h7FFF_FFFF);
        send_command(OP_PUSH, 5'd1, 32'h8000_0000);
        send_command(OP_PUSH, 5'd1, 32'h0000_0000);
        send_command(OP_PUSH, 5'd1, 32'hFFFF_FFFF);
        repeat (5) send_command(OP_POP, 5'd1, $urandom);
        send_command(OP_PUSH, 5'd0, 32'h1234_5678);
        send_command(OP_POP, 5'd0, 32'h0);
        send_command(OP_PUSH, 5'd2, 32'hDEAD_BEEF);
        send_command(OP_POP, 5'd31, 32'h0);

        write_count(5'd31);
        send_command(OP_PUSH, 5'd16, 32'hAAAA_AAAA);
        send_command(OP_PUSH, 5'd1, 32'h5555_5555);
        send_command(OP_POP, 5'd16, 32'h0);
        send_command(OP_POP, 5'd16, 32'h0);
        send_command(OP_PUSH, 5'd17, 32'h0F0F_0F0F);
        send_command(OP_PUSH, 5'd31, 32'hF0F0_F0F0);
        send_command(OP_POP, 5'd1, 32'h0);

        write_count(5'd16);
        send_command(OP_PUSH, 5'd16, $urandom);
        send_command(OP_POP, 5'd15, 32'h0);

        while (commands_sent < TOTAL_ITEMS) begin
            write_count(5'($urandom_range(0, 31)));
            phase_len = $urandom_range(40, 200);
            if (phase_len > TOTAL_ITEMS - commands_sent) begin
                phase_len = TOTAL_ITEMS - commands_sent;
            end
            focus = $urandom_range(1, tracker.active_count);
            push_pct = $urandom_range(40, 90);
            repeat (phase_len) begin
                pick = $urandom_range(0, 99);
                if (pick < 8) begin
                    num = 5'($urandom_range(0, 31));
                end else if (pick < 75) begin
                    num = 5'(focus);
                end else begin
                    num = 5'($urandom_range(1, tracker.active_count));
                end
                op = ($urandom_range(0, 99) < push_pct) ? OP_PUSH : OP_POP;
                send_command(op, num, $urandom);
            end
        end

        @(negedge i_clk);
        start <= 1'b0;
        while (tracker.expected_outcomes.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);

        $display("summary: %0d commands over %0d stack-count writes", commands_sent,
                 count_writes);
        $display("summary: ok %0d, invalid %0d, overflow %0d, empty %0d",
                 tracker.status_tally[ST_OK], tracker.status_tally[ST_INVALID],
                 tracker.status_tally[ST_OVERFLOW], tracker.status_tally[ST_EMPTY]);
        if (tracker.mismatches == 0 && tracker.expected_outcomes.size() == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule
